// ===== rtl/tpss_pkg.sv =====
// Package for the touch panel serial scanner: field widths, register
// indexes, reset values and the structs shared between modules.
// No dependencies.
package tpss_pkg;

  localparam int unsigned CmdW    = 8;
  localparam int unsigned PosW    = 12;
  localparam int unsigned TickW   = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HALF_PERIOD = 4'd0,
    REG_GAP_TICKS   = 4'd1,
    REG_CMD_X       = 4'd2,
    REG_CMD_Y       = 4'd3,
    REG_X_LOW       = 4'd4,
    REG_X_HIGH      = 4'd5,
    REG_Y_LOW       = 4'd6,
    REG_Y_HIGH      = 4'd7
  } cfg_reg_t;

  localparam logic [TickW-1:0] HalfPeriodRst = 8'd10;
  localparam logic [TickW-1:0] GapTicksRst   = 8'd10;
  localparam logic [CmdW-1:0]  CmdXRst       = 8'hD0;
  localparam logic [CmdW-1:0]  CmdYRst       = 8'h90;
  localparam logic [PosW-1:0]  XLowRst       = 12'd3100;
  localparam logic [PosW-1:0]  XHighRst      = 12'd3700;
  localparam logic [PosW-1:0]  YLowRst       = 12'd1500;
  localparam logic [PosW-1:0]  YHighRst      = 12'd1800;

  typedef struct packed {
    logic [TickW-1:0] half_period;
    logic [TickW-1:0] gap_ticks;
    logic [CmdW-1:0]  cmd_x;
    logic [CmdW-1:0]  cmd_y;
    logic [PosW-1:0]  x_low;
    logic [PosW-1:0]  x_high;
    logic [PosW-1:0]  y_low;
    logic [PosW-1:0]  y_high;
  } cfg_t;

  typedef struct packed {
    logic            cs_n;
    logic            sclk;
    logic            mosi;
    logic            busy_res;
    logic            done_res;
    logic [PosW-1:0] x_pos;
    logic [PosW-1:0] y_pos;
    logic            hit;
  } result_t;

endpackage

// ===== rtl/tpss_if.sv =====
// Valid/ready channel interfaces of the touch panel serial scanner:
// input tick, result and configuration write. Depends on tpss_pkg.
interface tpss_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic miso;
  modport source (output valid, start_req, miso, input ready);
  modport sink   (input valid, start_req, miso, output ready);
endinterface

interface tpss_res_if;
  logic                     valid;
  logic                     ready;
  logic                     cs_n;
  logic                     sclk;
  logic                     mosi;
  logic                     busy_res;
  logic                     done_res;
  logic [tpss_pkg::PosW-1:0] x_pos;
  logic [tpss_pkg::PosW-1:0] y_pos;
  logic                     hit;
  modport source (output valid, cs_n, sclk, mosi, busy_res, done_res, x_pos, y_pos, hit,
                  input ready);
  modport sink   (input valid, cs_n, sclk, mosi, busy_res, done_res, x_pos, y_pos, hit,
                  output ready);
endinterface

interface tpss_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tpss_pkg::CfgIdxW-1:0] index;
  logic [tpss_pkg::CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tpss_cfg_regs.sv =====
// Configuration register file of the touch panel serial scanner.
// Depends on tpss_pkg.
module tpss_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [tpss_pkg::CfgIdxW-1:0] wr_index,
  input  logic [tpss_pkg::CfgDatW-1:0] wr_data,
  output tpss_pkg::cfg_t cfg
);
  import tpss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= HalfPeriodRst;
      cfg.gap_ticks   <= GapTicksRst;
      cfg.cmd_x       <= CmdXRst;
      cfg.cmd_y       <= CmdYRst;
      cfg.x_low       <= XLowRst;
      cfg.x_high      <= XHighRst;
      cfg.y_low       <= YLowRst;
      cfg.y_high      <= YHighRst;
    end else if (wr_en) begin
      case (wr_index)
        REG_HALF_PERIOD: cfg.half_period <= wr_data[TickW-1:0];
        REG_GAP_TICKS:   cfg.gap_ticks   <= wr_data[TickW-1:0];
        REG_CMD_X:       cfg.cmd_x       <= wr_data[CmdW-1:0];
        REG_CMD_Y:       cfg.cmd_y       <= wr_data[CmdW-1:0];
        REG_X_LOW:       cfg.x_low       <= wr_data[PosW-1:0];
        REG_X_HIGH:      cfg.x_high      <= wr_data[PosW-1:0];
        REG_Y_LOW:       cfg.y_low       <= wr_data[PosW-1:0];
        REG_Y_HIGH:      cfg.y_high      <= wr_data[PosW-1:0];
        default: ;  // drop writes outside the register list
      endcase
    end
  end

endmodule

// ===== rtl/tpss_seq.sv =====
// Bit-level serial sequencer: advances one tick per accepted transaction
// and forms the result of that tick. Depends on tpss_pkg.
module tpss_seq #(
  parameter int unsigned CMD_BITS    = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            start_req,
  input  logic            miso,
  input  tpss_pkg::cfg_t  cfg,
  output tpss_pkg::result_t res
);
  import tpss_pkg::*;

  localparam int unsigned MaxBits = (CMD_BITS > SAMPLE_BITS) ? CMD_BITS : SAMPLE_BITS;
  localparam int unsigned BitW    = $clog2(MaxBits + 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_CMD_HI, PH_CMD_LO, PH_GAP, PH_RD_HI, PH_RD_LO, PH_CS_UP
  } phase_t;

  phase_t            phase, phase_next;
  logic              axis_is_y, axis_is_y_next;
  logic [BitW-1:0]   bit_count, bit_count_next;
  logic [TickW-1:0]  tick_count, tick_count_next;
  logic [CmdW-1:0]   out_shift, out_shift_next;
  logic [PosW-1:0]   in_shift, in_shift_next;
  logic [PosW-1:0]   x_hold, x_hold_next;
  logic [PosW-1:0]   y_hold, y_hold_next;
  logic              done, hit;

  logic [TickW:0]    tick_inc;
  logic [BitW-1:0]   bit_inc;
  logic              half_done, gap_done;

  assign tick_inc  = {1'b0, tick_count} + 1'b1;
  assign bit_inc   = bit_count + 1'b1;
  assign half_done = tick_inc >= {1'b0, cfg.half_period};
  assign gap_done  = tick_inc >= {1'b0, cfg.gap_ticks};

  always_comb begin
    phase_next      = phase;
    axis_is_y_next  = axis_is_y;
    bit_count_next  = bit_count;
    tick_count_next = tick_count;
    out_shift_next  = out_shift;
    in_shift_next   = in_shift;
    x_hold_next     = x_hold;
    y_hold_next     = y_hold;
    done            = 1'b0;
    hit             = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          axis_is_y_next  = 1'b0;
          out_shift_next  = cfg.cmd_x;
          bit_count_next  = '0;
          tick_count_next = '0;
          phase_next      = PH_CMD_HI;
        end
      end
      PH_CMD_HI: begin
        if (half_done) begin
          phase_next      = PH_CMD_LO;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
      end
      PH_CMD_LO: begin
        if (half_done) begin
          out_shift_next  = {out_shift[CmdW-2:0], 1'b0};
          tick_count_next = '0;
          if (bit_inc >= BitW'(CMD_BITS)) begin
            bit_count_next = '0;
            in_shift_next  = '0;
            phase_next     = (cfg.gap_ticks != '0) ? PH_GAP : PH_RD_HI;
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_CMD_HI;
          end
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
      end
      PH_GAP: begin
        if (gap_done) begin
          phase_next      = PH_RD_HI;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
      end
      PH_RD_HI: begin
        if (half_done) begin
          phase_next      = PH_RD_LO;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
      end
      PH_RD_LO: begin
        if (half_done) begin
          in_shift_next   = {in_shift[PosW-2:0], miso};
          tick_count_next = '0;
          if (bit_inc >= BitW'(SAMPLE_BITS)) begin
            bit_count_next = '0;
            if (!axis_is_y) begin
              x_hold_next    = in_shift_next;
              axis_is_y_next = 1'b1;
              phase_next     = PH_CS_UP;
            end else begin
              y_hold_next    = in_shift_next;
              axis_is_y_next = 1'b0;
              phase_next     = PH_IDLE;
              done           = 1'b1;
              hit = (x_hold > cfg.x_low) && (x_hold < cfg.x_high) &&
                    (in_shift_next > cfg.y_low) && (in_shift_next < cfg.y_high);
            end
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_RD_HI;
          end
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
      end
      PH_CS_UP: begin
        out_shift_next  = cfg.cmd_y;
        bit_count_next  = '0;
        tick_count_next = '0;
        phase_next      = PH_CMD_HI;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Result reflects the state after this tick.
  always_comb begin
    res.cs_n     = (phase_next == PH_IDLE) || (phase_next == PH_CS_UP);
    res.sclk     = (phase_next == PH_CMD_HI) || (phase_next == PH_RD_HI);
    res.mosi     = ((phase_next == PH_CMD_HI) || (phase_next == PH_CMD_LO)) ?
                   out_shift_next[CmdW-1] : 1'b0;
    res.busy_res = (phase_next != PH_IDLE);
    res.done_res = done;
    res.x_pos    = x_hold_next;
    res.y_pos    = y_hold_next;
    res.hit      = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      axis_is_y  <= 1'b0;
      bit_count  <= '0;
      tick_count <= '0;
      out_shift  <= '0;
      in_shift   <= '0;
      x_hold     <= '0;
      y_hold     <= '0;
    end else if (step) begin
      phase      <= phase_next;
      axis_is_y  <= axis_is_y_next;
      bit_count  <= bit_count_next;
      tick_count <= tick_count_next;
      out_shift  <= out_shift_next;
      in_shift   <= in_shift_next;
      x_hold     <= x_hold_next;
      y_hold     <= y_hold_next;
    end
  end

endmodule

// ===== rtl/tpss_out_buf.sv =====
// Result register with a skid stage, so input readiness never waits on
// the downstream ready in the same cycle. Depends on tpss_pkg.
module tpss_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tpss_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tpss_pkg::result_t out_data
);
  import tpss_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    out_free;

  assign push_ready = !skid_valid;
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/touch_panel_serial_scanner.sv =====
// Top level of the touch panel serial scanner: config registers, tick
// sequencer and result buffer. Depends on tpss_pkg, tpss_if and submodules.
//
//   channel  | role            | payload
//   ---------+-----------------+--------------------------------------------
//   tick     | tick in (sink)  | start_req, miso
//   report   | result (source) | cs_n, sclk, mosi, busy_res, done_res,
//            |                 | x_pos, y_pos, hit
//   cfg      | write (sink)    | index (4 bits), data (12 bits), always ready
//
// Every accepted tick transaction yields exactly one report transaction,
// registered in the result register, or in the skid stage while report
// stalls; one tick per cycle is sustained while report keeps up. A full X+Y
// scan spans 4 * (CMD_BITS + SAMPLE_BITS) * half_period + 2*gap_ticks + 2
// ticks, counting the start tick and the chip-select pause between the
// axes; a half_period of zero counts as one. Reset (rst, synchronous)
// returns the sequencer to idle and loads the default register values.
// When report stalls, one more tick is held in the skid stage; tick.ready
// then drops until the result drains.
module touch_panel_serial_scanner #(
  parameter int unsigned CMD_BITS    = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input logic         clk,
  input logic         rst,
  tpss_tick_if.sink   tick,
  tpss_res_if.source  report,
  tpss_cfg_if.sink    cfg
);
  import tpss_pkg::*;

  cfg_t    cfg_regs;
  result_t seq_res;
  result_t buf_res;
  logic    tick_ready;
  logic    tick_fire;

  // Config writes never stall.
  assign cfg.ready = 1'b1;

  tpss_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // Advance the sequencer only on an accepted tick transaction.
  assign tick.ready = tick_ready;
  assign tick_fire  = tick.valid && tick_ready;

  tpss_seq #(
    .CMD_BITS    (CMD_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (tick_fire),
    .start_req (tick.start_req),
    .miso      (tick.miso),
    .cfg       (cfg_regs),
    .res       (seq_res)
  );

  tpss_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (tick_fire),
    .push_data  (seq_res),
    .push_ready (tick_ready),
    .out_valid  (report.valid),
    .out_ready  (report.ready),
    .out_data   (buf_res)
  );

  assign report.cs_n     = buf_res.cs_n;
  assign report.sclk     = buf_res.sclk;
  assign report.mosi     = buf_res.mosi;
  assign report.busy_res = buf_res.busy_res;
  assign report.done_res = buf_res.done_res;
  assign report.x_pos    = buf_res.x_pos;
  assign report.y_pos    = buf_res.y_pos;
  assign report.hit      = buf_res.hit;

endmodule

// ===== bench/touch_panel_serial_scanner_test.sv =====
// Testbench for the touch panel serial scanner: drives tick transactions,
// predicts every report transaction tick by tick and compares field by field.
// Depends on tpss_pkg, the tpss channel interfaces and the scanner RTL.
`timescale 1ns / 100ps

module touch_panel_serial_scanner_test;
  import tpss_pkg::*;

  localparam int CmdBits    = 8;
  localparam int SampleBits = 12;
  localparam int PosMax     = (1 << PosW) - 1;
  localparam int RunLimit   = 4000000;
  localparam int LongHold   = 400;
  localparam int ItemTarget = 800;

  localparam logic [CfgIdxW-1:0] RegUnmappedLo = 4'd8;
  localparam logic [CfgIdxW-1:0] RegUnmappedHi = {CfgIdxW{1'b1}};

  // Sequencer phases of the scanner, in the order the block walks them.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_CMD_HIGH,
    SCAN_CMD_LOW,
    SCAN_GAP,
    SCAN_READ_HIGH,
    SCAN_READ_LOW,
    SCAN_CS_PAUSE
  } scan_phase_t;

  // One pending tick: when aimed, miso is steered at the moment the tick is
  // presented so that the X and Y reads return tx and ty.
  typedef struct packed {
    logic            start_req;
    logic            miso;
    logic            aimed;
    logic [PosW-1:0] tx;
    logic [PosW-1:0] ty;
  } tick_t;

  logic clk;
  logic rst;

  tpss_tick_if tick_ch ();
  tpss_res_if  report_ch ();
  tpss_cfg_if  cfg_ch ();

  touch_panel_serial_scanner i_dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .report (report_ch),
    .cfg    (cfg_ch)
  );

  // Shadow of the register file and of the sequencer state.
  cfg_t            shadow;
  scan_phase_t     scan_phase;
  logic            scan_axis_y;
  logic [3:0]      scan_bits;
  logic [TickW-1:0] scan_ticks;
  logic [CmdW-1:0] cmd_shift;
  logic [PosW-1:0] sample_shift;
  logic [PosW-1:0] x_sample;
  logic [PosW-1:0] y_sample;

  tick_t   tick_backlog[$];
  result_t pending_reports[$];
  tick_t   tick_now;
  result_t report_want;
  result_t report_got;

  int mismatch_cnt;
  int cycle_cnt;
  int send_pause;
  int recv_pause;
  int ticks_sent;
  int reg_writes;
  int scans_queued;
  int scans_seen;
  int hits_seen;
  bit steady;
  bit long_hold_req;

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > RunLimit) begin
      $display("TIMEOUT after %0d cycles, %0d reports still expected", cycle_cnt,
               pending_reports.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Scanner prediction
  // ------------------------------------------------------------------------

  function automatic void reset_scanner();
    shadow.half_period = HalfPeriodRst;
    shadow.gap_ticks   = GapTicksRst;
    shadow.cmd_x       = CmdXRst;
    shadow.cmd_y       = CmdYRst;
    shadow.x_low       = XLowRst;
    shadow.x_high      = XHighRst;
    shadow.y_low       = YLowRst;
    shadow.y_high      = YHighRst;
    scan_phase   = SCAN_IDLE;
    scan_axis_y  = 1'b0;
    scan_bits    = '0;
    scan_ticks   = '0;
    cmd_shift    = '0;
    sample_shift = '0;
    x_sample     = '0;
    y_sample     = '0;
  endfunction

  function automatic void load_command(logic [CmdW-1:0] cmd);
    cmd_shift  = cmd;
    scan_bits  = '0;
    scan_ticks = '0;
    scan_phase = SCAN_CMD_HIGH;
  endfunction

  // A half period of zero behaves as one tick.
  function automatic bit half_elapsed();
    return int'(scan_ticks) + 1 >= int'(shadow.half_period);
  endfunction

  // Advance the shadow sequencer by one accepted tick and queue the report
  // it must produce, taken from the state after the tick.
  function automatic void advance_scanner(tick_t t);
    logic    done_now;
    logic    hit_now;
    result_t r;
    done_now = 1'b0;
    hit_now  = 1'b0;
    case (scan_phase)
      SCAN_IDLE: begin
        // start while busy never reaches here, so it is dropped
        if (t.start_req) begin
          scan_axis_y = 1'b0;
          load_command(shadow.cmd_x);
        end
      end
      SCAN_CMD_HIGH: begin
        if (half_elapsed()) begin
          scan_phase = SCAN_CMD_LOW;
          scan_ticks = '0;
        end else scan_ticks++;
      end
      SCAN_CMD_LOW: begin
        if (half_elapsed()) begin
          cmd_shift  = cmd_shift << 1;
          scan_bits++;
          scan_ticks = '0;
          if (int'(scan_bits) >= CmdBits) begin
            scan_bits    = '0;
            sample_shift = '0;
            // a zero gap goes straight to sampling
            if (shadow.gap_ticks != '0) scan_phase = SCAN_GAP;
            else scan_phase = SCAN_READ_HIGH;
          end else scan_phase = SCAN_CMD_HIGH;
        end else scan_ticks++;
      end
      SCAN_GAP: begin
        if (int'(scan_ticks) + 1 >= int'(shadow.gap_ticks)) begin
          scan_phase = SCAN_READ_HIGH;
          scan_ticks = '0;
        end else scan_ticks++;
      end
      SCAN_READ_HIGH: begin
        if (half_elapsed()) begin
          scan_phase = SCAN_READ_LOW;
          scan_ticks = '0;
        end else scan_ticks++;
      end
      SCAN_READ_LOW: begin
        if (half_elapsed()) begin
          // sample on the last tick of the clock-low phase
          sample_shift = {sample_shift[PosW-2:0], t.miso};
          scan_bits++;
          scan_ticks = '0;
          if (int'(scan_bits) >= SampleBits) begin
            scan_bits = '0;
            if (!scan_axis_y) begin
              x_sample    = sample_shift;
              scan_axis_y = 1'b1;
              scan_phase  = SCAN_CS_PAUSE;
            end else begin
              y_sample    = sample_shift;
              scan_axis_y = 1'b0;
              scan_phase  = SCAN_IDLE;
              done_now    = 1'b1;
              hit_now     = (x_sample > shadow.x_low) && (x_sample < shadow.x_high) &&
                            (y_sample > shadow.y_low) && (y_sample < shadow.y_high);
            end
          end else scan_phase = SCAN_READ_HIGH;
        end else scan_ticks++;
      end
      SCAN_CS_PAUSE: load_command(shadow.cmd_y);
      default: scan_phase = SCAN_IDLE;
    endcase

    r.cs_n     = (scan_phase == SCAN_IDLE) || (scan_phase == SCAN_CS_PAUSE);
    r.sclk     = (scan_phase == SCAN_CMD_HIGH) || (scan_phase == SCAN_READ_HIGH);
    r.mosi     = ((scan_phase == SCAN_CMD_HIGH) || (scan_phase == SCAN_CMD_LOW)) ?
                 cmd_shift[CmdW-1] : 1'b0;
    r.busy_res = (scan_phase != SCAN_IDLE);
    r.done_res = done_now;
    r.x_pos    = x_sample;
    r.y_pos    = y_sample;
    r.hit      = hit_now;
    pending_reports.push_back(r);
  endfunction

  // Bit of the current target that the converter would be shifting out now.
  function automatic logic aimed_bit(tick_t t);
    logic [PosW-1:0] target;
    int              idx;
    target = scan_axis_y ? t.ty : t.tx;
    idx    = SampleBits - 1 - int'(scan_bits);
    if (idx < 0 || idx >= PosW) return 1'b0;
    return target[idx];
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int draw_pause();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ------------------------------------------------------------------------
  // Driver: present the next pending tick; advance the prediction on accept
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid     <= 1'b0;
      tick_ch.start_req <= 1'b0;
      tick_ch.miso      <= 1'b0;
      send_pause = 0;
      reset_scanner();
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        advance_scanner(tick_now);
        ticks_sent++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (send_pause > 0 || tick_backlog.size() == 0) begin
          if (send_pause > 0) send_pause--;
          tick_ch.valid <= 1'b0;
        end else begin
          tick_now = tick_backlog.pop_front();
          // steer miso from the state left by every tick accepted so far
          if (tick_now.aimed) tick_now.miso = aimed_bit(tick_now);
          tick_ch.valid     <= 1'b1;
          tick_ch.start_req <= tick_now.start_req;
          tick_ch.miso      <= tick_now.miso;
          send_pause = draw_pause();
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
      recv_pause = 0;
    end else begin
      if (long_hold_req) begin
        recv_pause    = LongHold;
        long_hold_req = 1'b0;
      end
      if (recv_pause > 0) begin
        report_ch.ready <= 1'b0;
        recv_pause--;
      end else begin
        report_ch.ready <= 1'b1;
        recv_pause = draw_pause();
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: compare each report transaction with the oldest expectation
  // ------------------------------------------------------------------------

  task automatic flag_mismatch(string what);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst && report_ch.valid && report_ch.ready) begin
      report_got.cs_n     = report_ch.cs_n;
      report_got.sclk     = report_ch.sclk;
      report_got.mosi     = report_ch.mosi;
      report_got.busy_res = report_ch.busy_res;
      report_got.done_res = report_ch.done_res;
      report_got.x_pos    = report_ch.x_pos;
      report_got.y_pos    = report_ch.y_pos;
      report_got.hit      = report_ch.hit;
      if (report_got.done_res === 1'b1) scans_seen++;
      if (report_got.hit === 1'b1) hits_seen++;
      if (pending_reports.size() == 0) begin
        flag_mismatch("report with no tick waiting for it");
      end else begin
        report_want = pending_reports.pop_front();
        check_field("cs_n", report_got.cs_n, report_want.cs_n);
        check_field("sclk", report_got.sclk, report_want.sclk);
        check_field("mosi", report_got.mosi, report_want.mosi);
        check_field("busy_res", report_got.busy_res, report_want.busy_res);
        check_field("done_res", report_got.done_res, report_want.done_res);
        check_field("x_pos", report_got.x_pos, report_want.x_pos);
        check_field("y_pos", report_got.y_pos, report_want.y_pos);
        check_field("hit", report_got.hit, report_want.hit);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  function automatic tick_t make_tick(logic s, logic m, logic a, logic [PosW-1:0] x,
                                      logic [PosW-1:0] y);
    tick_t t;
    t.start_req = s;
    t.miso      = m;
    t.aimed     = a;
    t.tx        = x;
    t.ty        = y;
    return t;
  endfunction

  // Hold until every tick has been accepted and every report has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_backlog.size() != 0 || tick_ch.valid || pending_reports.size() != 0);
  endtask

  // Feed idle ticks until the shadow sequencer is back in idle.
  task automatic settle_idle();
    wait_drained();
    while (scan_phase != SCAN_IDLE) begin
      repeat (32) tick_backlog.push_back(make_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0,
                                                   '0, '0));
      wait_drained();
    end
  endtask

  // Write one register; the shadow copy takes it at the accepting edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (cfg_reg_t'(idx))
      REG_HALF_PERIOD: shadow.half_period = val[TickW-1:0];
      REG_GAP_TICKS:   shadow.gap_ticks   = val[TickW-1:0];
      REG_CMD_X:       shadow.cmd_x       = val[CmdW-1:0];
      REG_CMD_Y:       shadow.cmd_y       = val[CmdW-1:0];
      REG_X_LOW:       shadow.x_low       = val[PosW-1:0];
      REG_X_HIGH:      shadow.x_high      = val[PosW-1:0];
      REG_Y_LOW:       shadow.y_low       = val[PosW-1:0];
      REG_Y_HIGH:      shadow.y_high      = val[PosW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Write every register once nothing is in flight; byte registers get junk
  // in the upper nibble, which must be dropped, and one write goes to an
  // unmapped index.
  task automatic write_all_regs(logic [7:0] hp, logic [7:0] gap, logic [7:0] cx,
                                logic [7:0] cy, logic [PosW-1:0] xl, logic [PosW-1:0] xh,
                                logic [PosW-1:0] yl, logic [PosW-1:0] yh);
    wait_drained();
    write_reg(REG_HALF_PERIOD, {4'($urandom), hp});
    write_reg(REG_GAP_TICKS, {4'($urandom), gap});
    write_reg(REG_CMD_X, {4'($urandom), cx});
    write_reg(REG_CMD_Y, {4'($urandom), cy});
    write_reg(REG_X_LOW, xl);
    write_reg(REG_X_HIGH, xh);
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_Y_HIGH, yh);
    write_reg(CfgIdxW'($urandom_range(RegUnmappedLo, RegUnmappedHi)), 12'($urandom));
  endtask

  // Queue one start and enough ticks for a full X+Y scan at the current
  // settings; start_noise sprinkles start requests that land while busy.
  task automatic queue_scan(logic [PosW-1:0] x, logic [PosW-1:0] y, bit aim,
                            bit start_noise);
    int hpe;
    int span;
    hpe  = (shadow.half_period == '0) ? 1 : int'(shadow.half_period);
    span = 4 * (CmdBits + SampleBits) * hpe + 2 * int'(shadow.gap_ticks) + 2;
    tick_backlog.push_back(make_tick(1'b1, 1'($urandom_range(0, 1)), aim, x, y));
    for (int k = 1; k < span; k++)
      tick_backlog.push_back(make_tick(start_noise && ($urandom_range(0, 15) == 0),
                                       1'($urandom_range(0, 1)), aim, x, y));
    scans_queued++;
  endtask

  // Directed scan from idle with exact target coordinates.
  task automatic directed_scan(logic [PosW-1:0] x, logic [PosW-1:0] y);
    settle_idle();
    queue_scan(x, y, 1'b1, 1'b0);
  endtask

  // Upper bound of a random window: usually a band above lo, sometimes
  // anywhere (inverted or empty windows included).
  function automatic logic [PosW-1:0] window_top(logic [PosW-1:0] lo);
    int hi;
    if ($urandom_range(0, 9) == 0) return PosW'($urandom_range(0, PosMax));
    hi = int'(lo) + $urandom_range(0, 1500);
    return PosW'((hi > PosMax) ? PosMax : hi);
  endfunction

  // Target coordinate: mostly inside the window, often on or next to an edge.
  function automatic logic [PosW-1:0] pick_coord(logic [PosW-1:0] lo, logic [PosW-1:0] hi);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 5 && int'(hi) > int'(lo) + 1) v = $urandom_range(int'(lo) + 1, int'(hi) - 1);
    else if (r < 7) v = ($urandom_range(0, 1) ? int'(lo) : int'(hi)) + $urandom_range(0, 2) - 1;
    else if (r < 8) v = $urandom_range(0, 1) ? PosMax : 0;
    else v = $urandom_range(0, PosMax);
    if (v < 0) v = 0;
    if (v > PosMax) v = PosMax;
    return PosW'(v);
  endfunction

  // One random phase: fresh settings, then one or two scans or noise.
  task automatic run_random_phase(bit hold_receiver);
    int              r;
    int              n_scans;
    logic [7:0]      hp;
    logic [7:0]      gap;
    logic [PosW-1:0] xl;
    logic [PosW-1:0] xh;
    logic [PosW-1:0] yl;
    logic [PosW-1:0] yh;
    settle_idle();
    steady = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 19);
    if (r < 12) hp = 8'd1;
    else if (r < 16) hp = 8'($urandom_range(2, 3));
    else if (r < 18) hp = 8'd0;
    else hp = 8'($urandom_range(4, 6));
    r = $urandom_range(0, 9);
    if (r < 4) gap = 8'd0;
    else if (r < 8) gap = 8'($urandom_range(1, 6));
    else gap = 8'($urandom_range(7, 20));
    xl = PosW'($urandom_range(0, PosMax));
    xh = window_top(xl);
    yl = PosW'($urandom_range(0, PosMax));
    yh = window_top(yl);
    write_all_regs(hp, gap, 8'($urandom), 8'($urandom), xl, xh, yl, yh);
    n_scans = $urandom_range(1, 2);
    for (int s = 0; s < n_scans; s++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        // broken sequence: random starts and data, no target
        repeat ($urandom_range(20, 120))
          tick_backlog.push_back(make_tick(1'($urandom_range(0, 3) == 0),
                                           1'($urandom_range(0, 1)), 1'b0, '0, '0));
      end else begin
        queue_scan(pick_coord(xl, xh), pick_coord(yl, yh), r != 1, 1'b1);
      end
    end
    // Stall the receiver while ticks are still queued so the skid stage
    // fills and the tick channel backs up.
    if (hold_receiver) begin
      @(negedge clk);
      long_hold_req = 1'b1;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    tick_ch.valid     = 1'b0;
    tick_ch.start_req = 1'b0;
    tick_ch.miso      = 1'b0;
    report_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    steady        = 1'b0;
    long_hold_req = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a start, two command bits and part of the third at the
    // default clocking, aimed inside the default window.
    tick_backlog.push_back(make_tick(1'b1, 1'b0, 1'b1, 12'd3400, 12'd1650));
    repeat (59) tick_backlog.push_back(make_tick(1'b0, 1'b0, 1'b1, 12'd3400, 12'd1650));
    scans_queued++;
    // Shorten the clocking mid-scan: the low phase in progress is already
    // past the new length and ends on the next tick. Finish the scan with
    // the default gap, Y command and window.
    wait_drained();
    write_reg(REG_HALF_PERIOD, 12'd1);
    do begin
      repeat (8) tick_backlog.push_back(make_tick(1'b0, 1'b0, 1'b1, 12'd3400, 12'd1650));
      wait_drained();
    end while (scan_phase != SCAN_IDLE);

    // Fastest clocking, no gap: window edges are exclusive, and start
    // requests while busy must be dropped.
    write_all_regs(8'd1, 8'd0, CmdXRst, CmdYRst, XLowRst, XHighRst, YLowRst, YHighRst);
    directed_scan(12'd3100, 12'd1650);
    settle_idle();
    queue_scan(12'd3101, 12'd1501, 1'b1, 1'b1);
    directed_scan(12'd3400, 12'd1800);

    // Half period of zero acts as one tick; all-ones and all-zeros commands.
    write_all_regs(8'd0, 8'd12, 8'hFF, 8'h00, XLowRst, XHighRst, YLowRst, YHighRst);
    directed_scan(12'h555, 12'hAAA);

    // Widest window, then an inverted one.
    write_all_regs(8'd1, 8'd1, 8'h00, 8'hFF, 12'd0, 12'hFFF, 12'd0, 12'hFFF);
    directed_scan(12'd1, 12'hFFE);
    write_all_regs(8'd1, 8'd2, 8'h5A, 8'hA5, 12'hFFF, 12'd0, 12'hFFF, 12'd0);
    directed_scan(12'd2048, 12'd2048);

    // Random phases until the tick budget is spent; the first one holds off
    // the receiver.
    for (int phase_no = 0;
         phase_no == 0 || ticks_sent + tick_backlog.size() < ItemTarget;
         phase_no++)
      run_random_phase(phase_no == 0);

    wait_drained();
    repeat (16) @(posedge clk);
    $display("Sent %0d ticks over %0d register writes; %0d scans queued.",
             ticks_sent, reg_writes, scans_queued);
    $display("%0d scans completed, %0d hits.", scans_seen, hits_seen);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== touch_panel_serial_scanner.f =====
rtl/tpss_pkg.sv
rtl/tpss_if.sv
rtl/tpss_cfg_regs.sv
rtl/tpss_seq.sv
rtl/tpss_out_buf.sv
rtl/touch_panel_serial_scanner.sv
bench/touch_panel_serial_scanner_test.sv
